@@ sv/ara_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ara_pkg
// Shared types, sizes and codes of the atlas rectangle allocator.
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int MAX_PAGES  = 16;
  localparam int FREE_SLOTS = 64;
  localparam int MAX_DIM    = 4096;

  localparam int DIM_W     = 13;
  localparam int PAGE_W    = 4;
  localparam int PIDX_W    = $clog2(MAX_PAGES);
  localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
  localparam int FIDX_W    = $clog2(FREE_SLOTS);
  localparam int FCNT_W    = $clog2(FREE_SLOTS + 1);
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_WIDTH  = 2'd0,
    REG_PAGE_HEIGHT = 2'd1,
    REG_INPUT_WIDTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [DIM_W-1:0]  bottom;
    logic [DIM_W-1:0]  right;
    logic [DIM_W-1:0]  top;
    logic [DIM_W-1:0]  left;
  } free_ent_t;

  typedef struct packed {
    logic [DIM_W-1:0] used_bottom;
    logic [DIM_W-1:0] used_right;
    logic [DIM_W-1:0] size_y;
    logic [DIM_W-1:0] size_x;
  } page_ent_t;

  // Page size: the default when it is large enough, else the next power of two.
  function automatic logic [DIM_W:0] grow_dim(input logic [DIM_W-1:0] def,
                                              input logic [DIM_W-1:0] need);
    logic [DIM_W:0] x;
    begin
      x = {1'b0, need} - (DIM_W+1)'(1);
      x = x | (x >> 1);
      x = x | (x >> 2);
      x = x | (x >> 4);
      x = x | (x >> 8);
      x = x + (DIM_W+1)'(1);
      grow_dim = (def >= need) ? {1'b0, def} : x;
    end
  endfunction

endpackage

@@ sv/atlas_rect_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlas_rect_allocator
// Best-fit free-rectangle packer for texture atlas pages.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                              | Direction
//  --------+--------------------------------------+-----------
//  items   | s_tvalid s_tready s_tdata s_tuser    | in
//  results | m_tvalid m_tready m_tdata            | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in
//
// One item is worked at a time. An allocate scans the free list and, when
// no free entry fits, the open pages: the free list and the page table each
// stream one entry a cycle through a single read port with registered data.
// Reset (synchronous) empties the free list and the page table; no
// clearing pass is needed. A result waits in the output register while
// the next item is taken; a stalled output holds the block only when a
// second result is ready behind it.
//
module atlas_rect_allocator (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // rect_width, rect_height, fixed_width_request, free_page, free_left,
  // free_top, free_right, free_bottom (lowest first), zero padded
  input  logic [ara_pkg::IN_DATA_W-1:0] s_tdata,
  // kind
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // status, placed_page, placed_left, placed_top, opened_page,
  // opened_width, opened_height, width_warning, free_list_dropped
  // (lowest first), zero padded
  output logic [ara_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [ara_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ara_pkg::DIM_W-1:0] cfg_data
);
  import ara_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FSCAN, S_FLAST, S_FMOVE, S_PSCAN, S_PLACE, S_OPEN, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [DIM_W-1:0] page_width, page_height, input_text_width;

  // item
  logic [DIM_W-1:0] w, h;

  // state counters
  logic [FCNT_W-1:0] free_count;
  logic [PCNT_W-1:0] page_count;
  logic [MAX_PAGES-1:0] used_valid;

  // scan control
  logic [FCNT_W-1:0] f_iss;
  logic [PCNT_W-1:0] p_iss;
  logic              pend;
  logic [FIDX_W-1:0] pend_fidx;
  logic [PIDX_W-1:0] pend_pidx;
  logic              found;
  logic [FIDX_W-1:0] best;
  logic [DIM_W-1:0]  bw, bh;
  free_ent_t         best_ent;

  // page hit
  logic              hit_right;
  logic [PIDX_W-1:0] hit_page;
  page_ent_t         hit_ent;

  // result
  status_t          r_status;
  logic [PAGE_W-1:0] r_page;
  logic [DIM_W-1:0] r_left, r_top, r_ow, r_oh;
  logic             r_opened, r_warn, r_dropped;

  // memories
  free_ent_t fmem [FREE_SLOTS];
  page_ent_t pmem [MAX_PAGES];
  free_ent_t f_rdata, f_wdata;
  page_ent_t p_rdata, p_wdata;
  logic      p_rvalid;
  logic [FIDX_W-1:0] f_raddr, f_waddr;
  logic [PIDX_W-1:0] p_raddr, p_waddr;
  logic f_we, p_we;

  // input fields
  kind_t             in_kind;
  logic [DIM_W-1:0]  in_rw, in_rh, in_fl, in_ft, in_fr, in_fb;
  logic              in_fixed;
  logic [PAGE_W-1:0] in_fpage;
  logic              accept;

  assign in_kind  = kind_t'(s_tuser);
  assign in_rw    = s_tdata[12:0];
  assign in_rh    = s_tdata[25:13];
  assign in_fixed = s_tdata[26];
  assign in_fpage = s_tdata[30:27];
  assign in_fl    = s_tdata[43:31];
  assign in_ft    = s_tdata[56:44];
  assign in_fr    = s_tdata[69:57];
  assign in_fb    = s_tdata[82:70];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // free entry compare
  logic [DIM_W:0] fw_s, fh_s;
  logic           fits, better;
  assign fw_s   = {1'b0, f_rdata.right} - {1'b0, f_rdata.left};
  assign fh_s   = {1'b0, f_rdata.bottom} - {1'b0, f_rdata.top};
  assign fits   = !fw_s[DIM_W] && !fh_s[DIM_W] &&
                  (w <= fw_s[DIM_W-1:0]) && (h <= fh_s[DIM_W-1:0]);
  assign better = !found || (fw_s[DIM_W-1:0] < bw);

  // shrink decision
  logic [DIM_W+3:0] w10, h10, bw9, bh9;
  assign w10 = ({4'b0, w} << 3) + ({4'b0, w} << 1);
  assign h10 = ({4'b0, h} << 3) + ({4'b0, h} << 1);
  assign bw9 = ({4'b0, bw} << 3) + {4'b0, bw};
  assign bh9 = ({4'b0, bh} << 3) + {4'b0, bh};

  // page compare
  logic [DIM_W-1:0] ur, ub;
  logic [DIM_W:0]   ur_w, ub_h;
  logic             fit_right, fit_below;
  assign ur        = p_rvalid ? p_rdata.used_right  : '0;
  assign ub        = p_rvalid ? p_rdata.used_bottom : '0;
  assign ur_w      = {1'b0, ur} + {1'b0, w};
  assign ub_h      = {1'b0, ub} + {1'b0, h};
  assign fit_right = (ur_w < {1'b0, p_rdata.size_x}) && (h <= p_rdata.size_y);
  assign fit_below = (ub_h < {1'b0, p_rdata.size_y}) && (w <= p_rdata.size_x);

  // placement on the hit page
  logic [DIM_W-1:0] nb, hur_w, hub_h;
  logic             push_right;
  assign nb         = (hit_ent.used_bottom > h) ? hit_ent.used_bottom : h;
  assign hur_w      = hit_ent.used_right + w;
  assign hub_h      = hit_ent.used_bottom + h;
  assign push_right = ((nb - h) >= h);

  // new page
  logic [DIM_W:0] pw, ph;
  assign pw = grow_dim(page_width, w);
  assign ph = grow_dim(page_height, h);

  logic f_full;
  assign f_full = (free_count >= FCNT_W'(FREE_SLOTS));

  // memory port control
  always_comb begin
    f_raddr = f_iss[FIDX_W-1:0];
    p_raddr = p_iss[PIDX_W-1:0];
    f_we    = 1'b0;
    f_waddr = free_count[FIDX_W-1:0];
    f_wdata = best_ent;
    p_we    = 1'b0;
    p_waddr = hit_page;
    p_wdata = hit_ent;
    case (state)
      S_IDLE: begin
        if (accept && in_kind == KIND_FREE && !f_full) begin
          f_we    = 1'b1;
          f_wdata = '{page: in_fpage, bottom: in_fb, right: in_fr,
                      top: in_ft, left: in_fl};
        end
      end
      S_FSCAN: begin
        if (!pend && f_iss == free_count && found) begin
          f_waddr = best;
          if (w10 < bw9) begin
            f_we          = 1'b1;
            f_wdata.left  = best_ent.left + w;
          end else if (h10 < bh9) begin
            f_we          = 1'b1;
            f_wdata.top   = best_ent.top + h;
          end
        end
      end
      S_FLAST: begin
        f_raddr = FIDX_W'(free_count - FCNT_W'(1));
      end
      S_FMOVE: begin
        f_we    = 1'b1;
        f_waddr = best;
        f_wdata = f_rdata;
      end
      S_PLACE: begin
        p_we = 1'b1;
        if (hit_right) begin
          p_wdata.used_right  = hur_w;
          p_wdata.used_bottom = nb;
          f_we    = push_right && !f_full;
          f_wdata = '{page: PAGE_W'(hit_page), bottom: nb, right: hur_w,
                      top: h, left: hit_ent.used_right};
        end else begin
          p_wdata.used_bottom = hub_h;
          f_we    = !f_full;
          f_wdata = '{page: PAGE_W'(hit_page), bottom: hub_h,
                      right: hit_ent.used_right, top: hit_ent.used_bottom, left: w};
        end
      end
      S_OPEN: begin
        p_waddr = page_count[PIDX_W-1:0];
        p_wdata = '{used_bottom: h, used_right: w,
                    size_y: ph[DIM_W-1:0], size_x: pw[DIM_W-1:0]};
        p_we    = (page_count < PCNT_W'(MAX_PAGES)) &&
                  (pw <= (DIM_W+1)'(MAX_DIM)) && (ph <= (DIM_W+1)'(MAX_DIM));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    f_rdata <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width       <= DIM_W'(512);
      page_height      <= DIM_W'(512);
      input_text_width <= DIM_W'(510);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAGE_WIDTH:  page_width       <= cfg_data;
        REG_PAGE_HEIGHT: page_height      <= cfg_data;
        REG_INPUT_WIDTH: input_text_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      page_count <= '0;
      used_valid <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // drop the output once taken; S_DONE reloads or holds it itself
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      p_rvalid <= used_valid[p_raddr];
      case (state)
        S_IDLE: begin
          if (accept) begin
            w         <= in_fixed ? input_text_width : in_rw;
            h         <= in_rh;
            r_status  <= ST_OK;
            r_page    <= '0;
            r_left    <= '0;
            r_top     <= '0;
            r_opened  <= 1'b0;
            r_ow      <= '0;
            r_oh      <= '0;
            r_warn    <= (in_kind == KIND_ALLOC) && in_fixed &&
                         (in_rw >= input_text_width);
            r_dropped <= (in_kind == KIND_FREE) && f_full;
            f_iss     <= '0;
            p_iss     <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            state     <= (in_kind == KIND_ALLOC) ? S_FSCAN : S_DONE;
            case (in_kind)
              KIND_FREE: begin
                if (!f_full) free_count <= free_count + FCNT_W'(1);
              end
              KIND_CLEAR: begin
                free_count <= '0;
                used_valid <= '0;
              end
              default: ;
            endcase
          end
        end
        S_FSCAN: begin
          // stream entries; compare the one read last cycle
          if (f_iss != free_count) begin
            pend      <= 1'b1;
            pend_fidx <= f_iss[FIDX_W-1:0];
            f_iss     <= f_iss + FCNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && fits && better) begin
            found    <= 1'b1;
            best     <= pend_fidx;
            bw       <= fw_s[DIM_W-1:0];
            bh       <= fh_s[DIM_W-1:0];
            best_ent <= f_rdata;
          end
          if (!pend && f_iss == free_count) begin
            if (found) begin
              r_page <= best_ent.page;
              r_left <= best_ent.left;
              r_top  <= best_ent.top;
              if (w10 < bw9 || h10 < bh9) state <= S_DONE;
              else state <= S_FLAST;
            end else begin
              state <= S_PSCAN;
            end
          end
        end
        S_FLAST: state <= S_FMOVE;
        S_FMOVE: begin
          free_count <= free_count - FCNT_W'(1);
          state      <= S_DONE;
        end
        S_PSCAN: begin
          if (p_iss != page_count) begin
            pend      <= 1'b1;
            pend_pidx <= p_iss[PIDX_W-1:0];
            p_iss     <= p_iss + PCNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && (fit_right || fit_below)) begin
            hit_right <= fit_right;
            hit_page  <= pend_pidx;
            hit_ent   <= '{used_bottom: ub, used_right: ur,
                           size_y: p_rdata.size_y, size_x: p_rdata.size_x};
            state     <= S_PLACE;
          end else if (!pend && p_iss == page_count) begin
            state <= S_OPEN;
          end
        end
        S_PLACE: begin
          used_valid[hit_page] <= 1'b1;
          r_page <= PAGE_W'(hit_page);
          if (hit_right) begin
            r_left <= hit_ent.used_right;
            r_top  <= '0;
          end else begin
            r_left <= '0;
            r_top  <= hit_ent.used_bottom;
          end
          if (!hit_right || push_right) begin
            if (f_full) r_dropped <= 1'b1;
            else free_count <= free_count + FCNT_W'(1);
          end
          state <= S_DONE;
        end
        S_OPEN: begin
          if (page_count >= PCNT_W'(MAX_PAGES)) begin
            r_status <= ST_NO_SLOT;
          end else if (pw > (DIM_W+1)'(MAX_DIM) || ph > (DIM_W+1)'(MAX_DIM)) begin
            r_status <= ST_TOO_BIG;
          end else begin
            used_valid[page_count[PIDX_W-1:0]] <= 1'b1;
            r_page     <= PAGE_W'(page_count[PIDX_W-1:0]);
            r_opened   <= 1'b1;
            r_ow       <= pw[DIM_W-1:0];
            r_oh       <= ph[DIM_W-1:0];
            page_count <= page_count + PCNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // load the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b0, r_dropped, r_warn, r_oh, r_ow, r_opened,
                         r_top, r_left, r_page, r_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ bench/atlas_rect_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlas_rect_allocator_checker
// Watches the item, result and register channels of the allocator, keeps its
// own copy of the page table and free list, predicts every placement result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module atlas_rect_allocator_checker
  import ara_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count
);

  typedef struct packed {
    logic             dropped;
    logic             warn;
    logic [DIM_W-1:0] open_h;
    logic [DIM_W-1:0] open_w;
    logic             opened;
    logic [DIM_W-1:0] ptop;
    logic [DIM_W-1:0] pleft;
    logic [3:0]       ppage;
    logic [1:0]       status;
  } placement_t;

  logic [DIM_W-1:0] def_w, def_h, text_w;
  int unsigned      n_pages, n_free;
  int unsigned      pg_x [MAX_PAGES], pg_y [MAX_PAGES];
  int unsigned      pg_r [MAX_PAGES], pg_b [MAX_PAGES];
  logic [3:0]       fr_pg [FREE_SLOTS];
  int unsigned      fr_l [FREE_SLOTS], fr_t [FREE_SLOTS];
  int unsigned      fr_r [FREE_SLOTS], fr_b [FREE_SLOTS];
  placement_t       placements_due [$];

  function automatic int unsigned page_dim(int unsigned dflt, int unsigned need);
    int unsigned p;
    p = 1;
    if (dflt >= need) return dflt;
    while (p < need) p = p << 1;
    return p;
  endfunction

  // Append a free rectangle; returns 1 when the list was already full.
  function automatic logic add_free(int unsigned pg, int unsigned l, int unsigned t,
                                    int unsigned r, int unsigned b);
    if (n_free >= FREE_SLOTS) return 1'b1;
    fr_pg[n_free] = pg[3:0];
    fr_l[n_free] = l & 13'h1FFF;
    fr_t[n_free] = t & 13'h1FFF;
    fr_r[n_free] = r & 13'h1FFF;
    fr_b[n_free] = b & 13'h1FFF;
    n_free++;
    return 1'b0;
  endfunction

  function automatic placement_t place_rect(kind_t kind, logic [IN_DATA_W-1:0] d);
    placement_t  res;
    int unsigned w, h, ur, ub, nb, pw, ph, best, rw;
    int          fw, fh, bw, bh;
    logic        found, placed;
    res = '0;
    if (kind == KIND_ALLOC) begin
      rw = 32'(d[12:0]);
      h  = 32'(d[25:13]);
      w  = d[26] ? 32'(text_w) : rw;
      res.warn = d[26] && rw >= 32'(text_w);
      found = 0; placed = 0; best = 0; bw = 0; bh = 0;
      for (int i = 0; i < n_free; i++) begin
        fw = int'(fr_r[i]) - int'(fr_l[i]);
        fh = int'(fr_b[i]) - int'(fr_t[i]);
        if (int'(w) <= fw && int'(h) <= fh && (!found || fw < bw)) begin
          found = 1; best = i; bw = fw; bh = fh;
        end
      end
      if (found) begin
        res.ppage = fr_pg[best];
        res.pleft = DIM_W'(fr_l[best]);
        res.ptop  = DIM_W'(fr_t[best]);
        if (10 * int'(w) < 9 * bw) fr_l[best] = (fr_l[best] + w) & 13'h1FFF;
        else if (10 * int'(h) < 9 * bh) fr_t[best] = (fr_t[best] + h) & 13'h1FFF;
        else begin
          n_free--;
          fr_pg[best] = fr_pg[n_free];
          fr_l[best] = fr_l[n_free]; fr_t[best] = fr_t[n_free];
          fr_r[best] = fr_r[n_free]; fr_b[best] = fr_b[n_free];
        end
      end else begin
        for (int i = 0; i < n_pages && !placed; i++) begin
          ur = pg_r[i]; ub = pg_b[i];
          if (ur + w < pg_x[i] && h <= pg_y[i]) begin
            nb = (ub > h) ? ub : h;
            res.ppage = 4'(i); res.pleft = DIM_W'(ur); res.ptop = '0;
            pg_r[i] = ur + w; pg_b[i] = nb;
            if (nb - h >= h) res.dropped = add_free(i, ur, h, ur + w, nb);
            placed = 1;
          end else if (ub + h < pg_y[i] && w <= pg_x[i]) begin
            res.ppage = 4'(i); res.pleft = '0; res.ptop = DIM_W'(ub);
            res.dropped = add_free(i, w, ub, ur, ub + h);
            pg_b[i] = ub + h;
            placed = 1;
          end
        end
        if (!placed) begin
          pw = page_dim(32'(def_w), w);
          ph = page_dim(32'(def_h), h);
          if (n_pages >= MAX_PAGES) res.status = ST_NO_SLOT;
          else if (pw > MAX_DIM || ph > MAX_DIM) res.status = ST_TOO_BIG;
          else begin
            pg_x[n_pages] = pw; pg_y[n_pages] = ph;
            pg_r[n_pages] = w;  pg_b[n_pages] = h;
            res.ppage = 4'(n_pages);
            res.opened = 1; res.open_w = DIM_W'(pw); res.open_h = DIM_W'(ph);
            n_pages++;
          end
        end
      end
    end else if (kind == KIND_FREE) begin
      res.dropped = add_free(32'(d[30:27]), 32'(d[43:31]), 32'(d[56:44]),
                             32'(d[69:57]), 32'(d[82:70]));
    end else if (kind == KIND_CLEAR) begin
      n_free = 0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        pg_r[i] = 0; pg_b[i] = 0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t want, got;
    if (rst) begin
      def_w <= DIM_W'(512); def_h <= DIM_W'(512); text_w <= DIM_W'(510);
      n_pages = 0; n_free = 0;
      placements_due.delete();
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PAGE_WIDTH:  def_w <= cfg_data;
          REG_PAGE_HEIGHT: def_h <= cfg_data;
          REG_INPUT_WIDTH: text_w <= cfg_data;
          default: ;
        endcase
      end
      // Compare before predicting: a result cannot come out in its own item's cycle.
      if (m_tvalid && m_tready) begin
        got = placement_t'(m_tdata[$bits(placement_t)-1:0]);
        result_count <= result_count + 1;
        if (placements_due.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = placements_due.pop_front();
          if (got !== want || m_tdata[OUT_DATA_W-1:$bits(placement_t)] !== '0) begin
            $display("%0t: mismatch expected st=%0d pg=%0d l=%0d t=%0d op=%0d ow=%0d oh=%0d wn=%0d dr=%0d",
                     $realtime, want.status, want.ppage, want.pleft, want.ptop, want.opened,
                     want.open_w, want.open_h, want.warn, want.dropped);
            $display("%0t:          actual   st=%0d pg=%0d l=%0d t=%0d op=%0d ow=%0d oh=%0d wn=%0d dr=%0d",
                     $realtime, got.status, got.ppage, got.pleft, got.ptop, got.opened,
                     got.open_w, got.open_h, got.warn, got.dropped);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        placements_due.push_back(place_rect(kind_t'(s_tuser), s_tdata));
      pending <= placements_due.size();
    end
  end

endmodule

@@ bench/tb_atlas_rect_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atlas_rect_allocator
// Drives allocate, free, clear and unknown items into the atlas allocator
// in bursts, changes page and text-width settings between phases, and stalls
// the result side; the checker predicts each result and reports mismatches.
// ----------------------------------------------------------------------------
module tb_atlas_rect_allocator;
  import ara_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = KIND_ALLOC;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PAGE_WIDTH;
  logic [DIM_W-1:0]      cfg_data = '0;
  int                    fail_count, pending, result_count;
  int                    item_count = 0;
  int                    burst_left = 0;
  int                    stall_mode = 0;

  always #6 clk = ~clk;

  atlas_rect_allocator i_dut (.*);

  atlas_rect_allocator_checker i_checker (.*);

  // Receiver: switch among always-ready, light and heavy stall patterns.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Present one item and hold it until the transfer; gaps come between bursts.
  task automatic send_item(kind_t kind, logic [IN_DATA_W-1:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    item_count++;
  endtask

  task automatic send_alloc(int unsigned w, int unsigned h, logic fixed);
    send_item(KIND_ALLOC, {61'(0), fixed, h[12:0], w[12:0]});
  endtask

  task automatic send_free(int unsigned pg, int unsigned l, int unsigned t,
                           int unsigned r, int unsigned b);
    send_item(KIND_FREE, {5'(0), b[12:0], r[12:0], t[12:0], l[12:0], pg[3:0], 27'(0)});
  endtask

  // Drain all results and let the block settle before a register write.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[12:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small allocations and sensible frees with random bits mixed in.
  task automatic random_item(int unsigned max_w, int unsigned max_h);
    int unsigned r, l, t;
    r = $urandom_range(0, 99);
    if (r < 62) send_alloc($urandom_range(0, max_w), $urandom_range(0, max_h),
                           $urandom_range(0, 9) == 0);
    else if (r < 64) send_alloc($urandom_range(0, 8191), $urandom_range(0, 8191),
                                1'($urandom_range(0, 1)));
    else if (r < 86) begin
      l = $urandom_range(0, 400); t = $urandom_range(0, 400);
      send_free($urandom_range(0, 15), l, t, l + $urandom_range(0, 120),
                t + $urandom_range(0, 120));
    end else if (r < 94) send_free($urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 98) send_item(KIND_CLEAR, IN_DATA_W'({$urandom, $urandom, $urandom}));
    else send_item(KIND_NONE, IN_DATA_W'({$urandom, $urandom, $urandom}));
  endtask

  initial begin
    #20_000_000;
    $display("atlas_rect_allocator test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every kind, page growth, overflows.
    send_alloc(0, 0, 0);
    send_alloc(600, 20, 0);
    send_alloc(8191, 8191, 0);
    send_alloc(4096, 4096, 0);
    send_alloc(4097, 1, 0);
    send_alloc(100, 5000, 1);
    send_alloc(511, 30, 1);
    send_alloc(10, 10, 0);
    send_free(15, 0, 0, 8191, 8191);
    send_free(0, 8191, 8191, 0, 0);
    send_free(3, 100, 100, 200, 200);
    send_alloc(50, 40, 0);
    send_alloc(95, 95, 0);
    send_alloc(200, 200, 0);
    send_item(KIND_NONE, '1);
    send_item(KIND_CLEAR, '0);
    send_alloc(300, 300, 0);
    send_alloc(300, 300, 0);
    for (int i = 0; i < 66; i++) send_free(i, 0, 0, 1, 1);
    for (int i = 0; i < 20; i++) send_alloc(4000, 4000, 0);
    send_item(KIND_CLEAR, '0);
    wait_idle();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_PAGE_WIDTH, 1); write_reg(REG_PAGE_HEIGHT, 1);
                 write_reg(REG_INPUT_WIDTH, 0); end
        1: begin write_reg(REG_PAGE_WIDTH, 4096); write_reg(REG_PAGE_HEIGHT, 4096);
                 write_reg(REG_INPUT_WIDTH, 4096); end
        2: begin write_reg(REG_PAGE_WIDTH, 256); write_reg(REG_PAGE_HEIGHT, 128);
                 write_reg(REG_INPUT_WIDTH, 60); end
        3: begin write_reg(REG_PAGE_WIDTH, 8191); write_reg(REG_PAGE_HEIGHT, 5000);
                 write_reg(REG_INPUT_WIDTH, 8191); end
        4: begin write_reg(REG_PAGE_WIDTH, $urandom_range(1, 4096));
                 write_reg(REG_PAGE_HEIGHT, $urandom_range(1, 4096));
                 write_reg(REG_INPUT_WIDTH, $urandom_range(0, 300)); end
        default: begin write_reg(REG_PAGE_WIDTH, 512); write_reg(REG_PAGE_HEIGHT, 512);
                 write_reg(REG_INPUT_WIDTH, 510); end
      endcase
      send_item(KIND_CLEAR, '0);
      for (int k = 0; k < 270; k++) begin
        random_item(ph == 1 ? 1500 : 150, ph == 1 ? 1500 : 150);
        if (k == 135) wait_idle();
      end
      wait_idle();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d items over six register settings; %0d results checked.",
             item_count, result_count);
    if (fail_count == 0) $display("atlas_rect_allocator test passed");
    else $display("atlas_rect_allocator test failed");
    $finish;
  end

endmodule
